// ===== hdl/acdsx_pkg.sv =====
// Package for the AES-128 counter-mode dual-stream XOR block.
// Holds the S-box, GF(2^8) helpers, register indexes and shared types.
package acdsx_pkg;

  localparam int unsigned StreamBlocksDefault = 1024;
  localparam int unsigned BlockBits = 128;
  localparam int unsigned Rounds = 10;
  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_CTR_HIGH = 2'd2,
    REG_CTR_LOW  = 2'd3
  } cfg_reg_e;

  // One queued job: the counter block to encrypt and the data to XOR with it.
  typedef struct packed {
    logic [BlockBits-1:0] ctr;
    logic [BlockBits-1:0] data;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[v];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit big-endian word sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] byte_at(input logic [BlockBits-1:0] w, input int i);
    return w[BlockBits-1-8*i -: 8];
  endfunction

endpackage

// ===== hdl/acdsx_front.sv =====
// Front end: accepts input transactions, forms the counter block for the
// selected stream and keeps the send and receive indices. Uses acdsx_pkg.
module acdsx_front import acdsx_pkg::*; #(
  parameter int unsigned StreamBlocks = StreamBlocksDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 dir_i,
  input  logic [BlockBits-1:0] data_i,
  input  logic [BlockBits-1:0] ctr_start_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output job_t                 job_o
);
  localparam int unsigned IdxBits = $clog2(StreamBlocks);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(StreamBlocks - 1);

  logic [IdxBits-1:0] send_idx_q, send_idx_d, recv_idx_q, recv_idx_d, idx;
  logic [1:0]         cnt_q, cnt_d;
  job_t               slot_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;
  assign idx         = dir_i ? send_idx_q : recv_idx_q;

  always_comb begin
    send_idx_d = send_idx_q;
    recv_idx_d = recv_idx_q;
    if (push) begin
      if (dir_i) begin
        send_idx_d = (send_idx_q == LastIdx) ? '0 : send_idx_q + 1'b1;
      end else begin
        recv_idx_d = (recv_idx_q == LastIdx) ? '0 : recv_idx_q + 1'b1;
      end
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_idx_q <= '0;
      recv_idx_q <= '0;
      cnt_q      <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
    end else begin
      send_idx_q <= send_idx_d;
      recv_idx_q <= recv_idx_d;
      cnt_q      <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // The two-entry queue decouples index handling from the cipher core.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q].ctr  <= ctr_start_i + {{(BlockBits-IdxBits){1'b0}}, idx};
      slot_q[wr_ptr_q].data <= data_i;
    end
  end
endmodule

// ===== hdl/acdsx_core.sv =====
// Back end: iterative AES-128 round unit with on-the-fly key expansion,
// XOR of the keystream with the data, and an output register. Uses acdsx_pkg.
module acdsx_core import acdsx_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  job_t                 job_i,
  input  logic [BlockBits-1:0] key_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BlockBits-1:0] out_data_o
);
  typedef enum logic [1:0] {ST_IDLE, ST_RUN} state_e;

  state_e               state_q;
  logic [3:0]           round_q;
  logic [BlockBits-1:0] st_q, rk_q, data_q, res_q;
  logic [7:0]           rcon_q;
  logic                 ov_q;
  logic [BlockBits-1:0] sb, mc, rnd, nrk;
  logic [31:0]          t;
  logic                 last, done_ok;

  always_comb begin
    // SubBytes with ShiftRows folded in.
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sb[BlockBits-1-8*(i+4*c) -: 8] = sbox(byte_at(st_q, i + 4*((c+i) & 3)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, tt;
      a0 = byte_at(sb, 4*c);
      a1 = byte_at(sb, 4*c+1);
      a2 = byte_at(sb, 4*c+2);
      a3 = byte_at(sb, 4*c+3);
      tt = a0 ^ a1 ^ a2 ^ a3;
      mc[BlockBits-1-32*c -: 32] = {a0 ^ tt ^ xtime(a0 ^ a1), a1 ^ tt ^ xtime(a1 ^ a2),
                                    a2 ^ tt ^ xtime(a2 ^ a3), a3 ^ tt ^ xtime(a3 ^ a0)};
    end
    t = {sbox(rk_q[23:16]) ^ rcon_q, sbox(rk_q[15:8]), sbox(rk_q[7:0]), sbox(rk_q[31:24])};
    nrk[127:96] = rk_q[127:96] ^ t;
    nrk[95:64]  = rk_q[95:64] ^ nrk[127:96];
    nrk[63:32]  = rk_q[63:32] ^ nrk[95:64];
    nrk[31:0]   = rk_q[31:0] ^ nrk[63:32];
    last = (round_q == 4'(Rounds));
    rnd  = (last ? sb : mc) ^ nrk;
  end

  assign done_ok     = !ov_q || out_ready_i;
  assign job_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      rcon_q  <= 8'h01;
      ov_q    <= 1'b0;
    end else begin
      // Final round result lands in the output register.
      if (state_q == ST_RUN && last && done_ok) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            state_q <= ST_RUN;
            round_q <= 4'd1;
            rcon_q  <= 8'h01;
          end
        end
        ST_RUN: begin
          if (!last) begin
            round_q <= round_q + 4'd1;
            rcon_q  <= xtime(rcon_q);
          end else if (done_ok) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      st_q   <= job_i.ctr ^ key_i;
      rk_q   <= key_i;
      data_q <= job_i.data;
    end else if (state_q == ST_RUN && !last) begin
      st_q <= rnd;
      rk_q <= nrk;
    end
    if (state_q == ST_RUN && last && done_ok) res_q <= rnd ^ data_q;
  end
endmodule

// ===== hdl/aes_ctr_dual_stream_xor.sv =====
// Top level of the AES-128 counter-mode dual-stream XOR block.
// Holds the configuration registers; uses acdsx_front, acdsx_core, acdsx_pkg.
//
// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tdata = {block_low, block_high}, tuser = direction
// m_axis    out  tvalid/tready         tdata = {result_low, result_high}
// cfg       in   cfg_valid/cfg_ready   cfg_index_i, cfg_data_i
//
// Each block passes through the round unit as a load step followed by ten rounds;
// the unit takes a new block only when idle, once the previous result is registered.
// Reset empties the queue and clears the indices and configuration registers to
// zero. A two-entry queue sits between the index front end and the round unit, and the
// output register holds a result while the next block is already being encrypted.
module aes_ctr_dual_stream_xor import acdsx_pkg::*; #(
  parameter int unsigned StreamBlocks = StreamBlocksDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [127:0]          s_axis_tdata,   // block_high[63:0], block_low[127:64]
  input  logic                  s_axis_tuser,   // direction
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [127:0]          m_axis_tdata,   // result_high[63:0], result_low[127:64]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [63:0]           cfg_data_i
);
  logic [63:0] key_hi_q, key_lo_q, ctr_hi_q, ctr_lo_q;
  logic        job_valid, job_ready;
  job_t        job;
  logic [127:0] res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      ctr_hi_q <= '0;
      ctr_lo_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        REG_CTR_HIGH: ctr_hi_q <= cfg_data_i;
        REG_CTR_LOW:  ctr_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acdsx_front #(.StreamBlocks(StreamBlocks)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dir_i       (s_axis_tuser),
    .data_i      ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .ctr_start_i ({ctr_hi_q, ctr_lo_q}),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  acdsx_core u_core (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .key_i       ({key_hi_q, key_lo_q}),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule
